// ----- src/ngcv_pkg.sv -----
// Package: constants and types shared by the nearest grid cell search block.
`timescale 1ns / 1ps
`default_nettype none
package ngcv_pkg;
	localparam int GRID_SIDE  = 64;
	localparam int CODE_BITS  = 4;
	localparam int COORD_BITS = $clog2(GRID_SIDE);
	localparam int ADDR_BITS  = 2 * COORD_BITS;
	localparam int CELLS      = GRID_SIDE * GRID_SIDE;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_FIND  = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [CODE_BITS-1:0]  code_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	// One candidate cell read back from the store, plus search control.
	typedef struct packed {
		logic   clr;
		logic   vld;
		coord_t cx;
		coord_t cy;
		code_t  code;
		coord_t px;
		coord_t py;
		code_t  seek;
	} cand_t;
endpackage
`default_nettype wire

// ----- src/ngcv_best.sv -----
// Chebyshev distance of each candidate and tracking of the nearest match.
`timescale 1ns / 1ps
`default_nettype none
module ngcv_best (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ngcv_pkg::cand_t cand,
	output logic               hit,
	output ngcv_pkg::coord_t   best_x,
	output ngcv_pkg::coord_t   best_y
);
	import ngcv_pkg::*;

	logic   hit_q;
	coord_t best_d_q, best_x_q, best_y_q;
	coord_t dx, dy, d;
	logic   take;

	always_comb begin
		dx   = (cand.cx > cand.px) ? (cand.cx - cand.px) : (cand.px - cand.cx);
		dy   = (cand.cy > cand.py) ? (cand.cy - cand.py) : (cand.py - cand.cy);
		d    = (dx > dy) ? dx : dy;
		take = cand.vld && (cand.code == cand.seek) && (!hit_q || d < best_d_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cand.clr) begin
			hit_q <= 1'b0;
		end else if (take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !cand.clr) begin
			best_d_q <= d;
			best_x_q <= cand.cx;
			best_y_q <= cand.cy;
		end
	end

	assign hit    = hit_q;
	assign best_x = best_x_q;
	assign best_y = best_y_q;

	a_dist_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(hit_q) && hit_q && !$past(cand.clr) |-> best_d_q <= $past(best_d_q))
		else $error("best distance grew");
	a_clr_drops: assert property (@(posedge clk) disable iff (!arst_n)
		cand.clr |=> !hit_q)
		else $error("hit survived clear");
	a_no_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cand.clr |-> !cand.vld)
		else $error("candidate during clear");
endmodule
`default_nettype wire

// ----- src/nearest_grid_cell_of_value.sv -----
// Top level: grid store, scan sequencer and result port of the nearest cell search.
//
//  channel   signals                              transaction
//  command   start, busy, action, x, y, value     start && !busy
//  result    done, found, found_x, found_y        done (one cycle)
//
// A write leaves busy low; the next command may follow at once. A find reads every cell
// once, one store read per cycle, busy through the scan, drain and report states, the
// result strobe falling in the last. The single store read port sets this read rate.
// Reset clears the sequencer and the match flag; store contents stay undefined.
// The receiver cannot stall; done is high for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module nearest_grid_cell_of_value (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             action,
	input  wire ngcv_pkg::coord_t x,
	input  wire ngcv_pkg::coord_t y,
	input  wire ngcv_pkg::code_t  value,
	output logic                  done,
	output logic                  found,
	output ngcv_pkg::coord_t      found_x,
	output ngcv_pkg::coord_t      found_y
);
	import ngcv_pkg::*;

	code_t  mem [CELLS];
	state_t state_q;
	addr_t  addr_q, addr_s1;
	code_t  rd_s1;
	logic   vld_s1;
	coord_t px_q, py_q;
	code_t  seek_q;
	logic   acc, wr_en, find_go;
	cand_t  cand;
	logic   hit;
	coord_t best_x, best_y;

	assign busy    = (state_q != ST_IDLE);
	assign acc     = start && !busy;
	assign wr_en   = acc && (action == ACT_WRITE);
	assign find_go = acc && (action == ACT_FIND);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{x, y}] <= value;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1   <= mem[addr_q];
		addr_s1 <= addr_q;
		if (find_go) begin
			px_q   <= x;
			py_q   <= y;
			seek_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (find_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == addr_t'(CELLS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cand.clr  = find_go;
		cand.vld  = vld_s1;
		cand.cx   = addr_s1[ADDR_BITS-1:COORD_BITS];
		cand.cy   = addr_s1[COORD_BITS-1:0];
		cand.code = rd_s1;
		cand.px   = px_q;
		cand.py   = py_q;
		cand.seek = seek_q;
	end

	ngcv_best u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.cand   (cand),
		.hit    (hit),
		.best_x (best_x),
		.best_y (best_y)
	);

	assign done    = (state_q == ST_REPORT);
	assign found   = hit;
	assign found_x = hit ? best_x : '0;
	assign found_y = hit ? best_y : '0;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held over two cycles");
	a_done_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_DRAIN)
		else $error("done without completed scan");
	a_find_busy: assert property (@(posedge clk) disable iff (!arst_n)
		find_go |=> busy && addr_q == '0)
		else $error("find did not start scan");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> !busy)
		else $error("write left block busy");
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && $past(vld_s1) |-> addr_s1 == $past(addr_s1) + 1'b1)
		else $error("scan skipped a cell");
endmodule
`default_nettype wire
